FILE: hdl/set_assoc_cache_tag_controller_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set associative cache tag controller
// Shared helpers for concurrent checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define SACTC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sactc check failed");

// next-cycle implication
`define SACTC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sactc check failed");

`endif

FILE: hdl/sactc_pkg.sv
// ----------------------------------------------------------------------------
// sactc_pkg
// Types, codes and defaults for the cache tag controller.
// ----------------------------------------------------------------------------
package sactc_pkg;

  localparam int DEF_SETS       = 256;
  localparam int DEF_WAYS       = 8;
  localparam int DEF_ADDR_BITS  = 32;
  localparam int DEF_STAMP_BITS = 32;

  localparam int TAG_W = 24;
  localparam int CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  localparam logic [1:0] POLICY_LRU  = 2'd0;
  localparam logic [1:0] POLICY_RAND = 2'd1;
  localparam logic [1:0] POLICY_PART = 2'd2;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_WAYS   = 2'd1;
  localparam logic [1:0] REG_QUOTA  = 2'd2;

  localparam logic MODE_LOOKUP  = 1'b0;
  localparam logic MODE_INSTALL = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_RD,
    ST_SCAN,
    ST_RAND,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] blk_addr;
    logic        write_op;
    logic        core_id;
    logic [31:0] timestamp;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [2:0]       victim_way;
    logic             no_victim;
    logic             evict_valid;
    logic             evict_dirty;
    logic [TAG_W-1:0] evict_tag;
    logic             evict_core;
    logic [CNT_W-1:0] read_accesses;
    logic [CNT_W-1:0] write_accesses;
    logic [CNT_W-1:0] read_misses;
    logic [CNT_W-1:0] write_misses;
    logic [CNT_W-1:0] dirty_evictions;
  } rsp_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

FILE: hdl/sactc_ram.sv
// ----------------------------------------------------------------------------
// sactc_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module sactc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/sactc_div.sv
// ----------------------------------------------------------------------------
// sactc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sactc_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [DEN_W-1:0] rem
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt;
  logic             busy;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] dsr;
  logic [DEN_W:0]   r_shift;
  logic             r_ge;

  assign r_shift = {rem, quo[NUM_W-1]};
  assign r_ge    = r_shift >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dsr <= den;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], r_ge};
      rem <= r_ge ? DEN_W'(r_shift - {1'b0, dsr}) : DEN_W'(r_shift);
    end
  end

endmodule

FILE: hdl/set_assoc_cache_tag_controller.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller
// Tag store of a set associative cache with LRU, random and partitioned
// replacement and saturating event counters.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one lookup or install beat;
//   out channel (out_valid/out_ready/out_data) returns one result beat each.
//   cfg_we/cfg_index/cfg_data write policy, ways in use and core 0 quota;
//   write only while the block is idle.
// Flow: an item reads its whole set in one RAM access, scans one way per
//   cycle, then writes the set back. A random victim also passes through
//   the LFSR modulo divider, and a non power of two set count adds the
//   reciprocal set index split. One item is in flight at a time.
// Reset: a clearing pass writes every set to zero, with in_ready low;
//   configuration writes are still taken.
// Stall: a finished result sits in the output register; the next item is
//   accepted and worked on, and waits in its write back step until the
//   previous beat has been taken.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_tag_controller_defines.svh"

module set_assoc_cache_tag_controller
  import sactc_pkg::*;
#(
  parameter int SETS       = DEF_SETS,
  parameter int WAYS       = DEF_WAYS,
  parameter int ADDR_BITS  = DEF_ADDR_BITS,
  parameter int STAMP_BITS = DEF_STAMP_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output rsp_t       out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int  SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int  SET_SH    = $clog2(SETS);
  localparam bit  SETS_POW2 = ((SETS & (SETS - 1)) == 0);
  localparam int  ADDR_W    = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int  STAMP_W   = (STAMP_BITS < 32) ? STAMP_BITS : 32;
  localparam int  ENT_W     = 3 + TAG_W + STAMP_W;
  localparam int  ROW_W     = WAYS * ENT_W;
  localparam int  WIDX_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int  NW_W      = $clog2(WAYS + 1);
  localparam int  DIV_W     = 16;
  localparam int  DEN_W     = NW_W;
  localparam int  O_STAMP   = 0;
  localparam int  O_TAG     = STAMP_W;
  localparam int  O_OWNER   = STAMP_W + TAG_W;
  localparam int  O_DIRTY   = STAMP_W + TAG_W + 1;
  localparam int  O_VALID   = STAMP_W + TAG_W + 2;
  // ceil(2^(32+SET_SH) / SETS), 33 bits; the top bit is folded in as a shift
  localparam logic [63:0] RECIP =
      ((64'd1 << (32 + SET_SH)) + 64'(SETS) - 64'd1) / 64'(SETS);
  localparam logic [31:0] RECIP_LO = RECIP[31:0];

  state_t state, state_next;

  logic [1:0] policy;
  logic [3:0] ways_in_use;
  logic [3:0] core0_quota;

  req_t             req;
  logic [SET_W-1:0] req_set;
  logic [TAG_W-1:0] req_tag;
  logic [SET_W-1:0] clr_addr;
  logic [15:0]      lfsr, lfsr_next;

  logic [ROW_W-1:0] row, ram_rdata, ram_wdata;
  logic             ram_we, ram_re;
  logic [SET_W-1:0] ram_waddr, ram_raddr;

  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den, div_rem;

  logic [31:0]      addr32_in, req_a32, rc_quo, rc_rem;
  logic [63:0]      rc_prod;
  logic [64:0]      rc_sum;
  logic [SET_W-1:0] rc_set;
  logic             addr_ph;

  logic [WIDX_W-1:0]  scan_w, hit_way, inv_way, any_way, c0_way, c1_way, rand_way;
  logic               hit_found, inv_found, any_found, c0_found, c1_found;
  logic [STAMP_W-1:0] any_stamp, c0_stamp, c1_stamp;
  logic [NW_W-1:0]    n0, nways, q0;
  logic [4:0]         nw_raw;
  logic               scan_last, need_rand;

  logic [ADDR_W-1:0]  addr_in;
  logic [ENT_W-1:0]   ent, pick_ent, new_ent;
  logic [WIDX_W-1:0]  pick_way;
  logic               pick_found, over0, over1, use_c0, decide_go;

  logic [CNT_W-1:0] cnt_ra, cnt_wa, cnt_rm, cnt_wm, cnt_de;
  logic [CNT_W-1:0] cnt_ra_next, cnt_wa_next, cnt_rm_next, cnt_wm_next, cnt_de_next;
  rsp_t             rsp;

  assign addr_in   = in_data.blk_addr[ADDR_W-1:0];
  assign addr32_in = 32'(addr_in);
  assign req_a32   = 32'(req.blk_addr[ADDR_W-1:0]);

  // set index split by reciprocal multiplication
  assign rc_sum = {1'b0, req_a32, 32'd0} + {1'b0, rc_prod};
  assign rc_rem = req_a32 - 32'(rc_quo * 32'(SETS));
  assign rc_set = SET_W'(rc_rem);

  // effective associativity and quota
  assign nw_raw = (ways_in_use == 4'd0) ? 5'd1 : {1'b0, ways_in_use};
  assign nways  = (nw_raw > 5'(WAYS)) ? NW_W'(WAYS) : NW_W'(nw_raw);
  assign q0     = ({1'b0, core0_quota} > 5'(nways)) ? nways : NW_W'(core0_quota);

  assign ent       = row[scan_w * ENT_W +: ENT_W];
  assign scan_last = (scan_w == WIDX_W'(nways - 1'b1));
  // only looked at on the last scan step, where the current way counts too
  assign need_rand = (req.mode == MODE_INSTALL) && !inv_found && ent[O_VALID]
                     && (policy == POLICY_RAND);

  assign lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
  assign decide_go = !(out_valid && !out_ready);

  sactc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS),
    .AW    (SET_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sactc_div #(
    .NUM_W (DIV_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .rem   (div_rem)
  );

  // victim choice
  always_comb begin
    over0      = n0 > q0;
    over1      = q0 > n0;
    use_c0     = over0 || (!req.core_id && !over1);
    pick_found = 1'b0;
    pick_way   = '0;
    if (req.mode == MODE_LOOKUP) begin
      pick_found = hit_found;
      pick_way   = hit_way;
    end else if (inv_found) begin
      pick_found = 1'b1;
      pick_way   = inv_way;
    end else begin
      case (policy)
        POLICY_RAND: begin
          pick_found = 1'b1;
          pick_way   = rand_way;
        end
        POLICY_PART: begin
          pick_found = use_c0 ? c0_found : c1_found;
          pick_way   = use_c0 ? c0_way : c1_way;
        end
        default: begin
          pick_found = any_found;
          pick_way   = any_way;
        end
      endcase
    end
  end

  always_comb begin
    pick_ent = row[pick_way * ENT_W +: ENT_W];
    new_ent  = pick_ent;
    if (req.mode == MODE_LOOKUP) begin
      new_ent[O_STAMP +: STAMP_W] = req.timestamp[STAMP_W-1:0];
      new_ent[O_DIRTY]            = pick_ent[O_DIRTY] | req.write_op;
    end else begin
      new_ent[O_STAMP +: STAMP_W] = req.timestamp[STAMP_W-1:0];
      new_ent[O_TAG +: TAG_W]     = req_tag;
      new_ent[O_OWNER]            = req.core_id;
      new_ent[O_DIRTY]            = req.write_op;
      new_ent[O_VALID]            = 1'b1;
    end
  end

  always_comb begin
    cnt_ra_next = cnt_ra;
    cnt_wa_next = cnt_wa;
    cnt_rm_next = cnt_rm;
    cnt_wm_next = cnt_wm;
    cnt_de_next = cnt_de;
    if (req.mode == MODE_LOOKUP) begin
      if (req.write_op) begin
        cnt_wa_next = sat_inc(cnt_wa);
        if (!hit_found) cnt_wm_next = sat_inc(cnt_wm);
      end else begin
        cnt_ra_next = sat_inc(cnt_ra);
        if (!hit_found) cnt_rm_next = sat_inc(cnt_rm);
      end
    end else if (pick_found && pick_ent[O_VALID] && pick_ent[O_DIRTY]) begin
      cnt_de_next = sat_inc(cnt_de);
    end
  end

  always_comb begin
    rsp                 = '0;
    rsp.read_accesses   = cnt_ra_next;
    rsp.write_accesses  = cnt_wa_next;
    rsp.read_misses     = cnt_rm_next;
    rsp.write_misses    = cnt_wm_next;
    rsp.dirty_evictions = cnt_de_next;
    if (req.mode == MODE_LOOKUP) begin
      rsp.hit = hit_found;
    end else if (!pick_found) begin
      rsp.no_victim = 1'b1;
    end else begin
      rsp.victim_way = 3'(pick_way);
      if (pick_ent[O_VALID]) begin
        rsp.evict_valid = 1'b1;
        rsp.evict_dirty = pick_ent[O_DIRTY];
        rsp.evict_tag   = pick_ent[O_TAG +: TAG_W];
        rsp.evict_core  = pick_ent[O_OWNER];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      ram_wdata[i * ENT_W +: ENT_W] = (state == ST_CLEAR) ? '0 :
          ((WIDX_W'(i) == pick_way) ? new_ent : row[i * ENT_W +: ENT_W]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == SET_W'(SETS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = SETS_POW2 ? ST_RD : ST_ADDR;
      ST_ADDR:   if (addr_ph) state_next = ST_RD;
      ST_RD:     state_next = ST_SCAN;
      ST_SCAN:   if (scan_last) state_next = need_rand ? ST_RAND : ST_DECIDE;
      ST_RAND:   if (div_done) state_next = ST_DECIDE;
      ST_DECIDE: if (decide_go) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = req_set;
    ram_re    = 1'b0;
    ram_raddr = req_set;
    div_start = 1'b0;
    div_num   = lfsr_next;
    div_den   = DEN_W'(nways);
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && SETS_POW2) begin
          ram_re    = 1'b1;
          ram_raddr = SET_W'(addr_in & ADDR_W'(SETS - 1));
        end
      end
      ST_ADDR: begin
        if (addr_ph) begin
          ram_re    = 1'b1;
          ram_raddr = rc_set;
        end
      end
      ST_SCAN: begin
        if (scan_last && need_rand) begin
          div_start = 1'b1;
        end
      end
      ST_DECIDE: begin
        ram_we = decide_go && pick_found;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      policy      <= POLICY_LRU;
      ways_in_use <= 4'd8;
      core0_quota <= 4'd4;
      lfsr        <= LFSR_SEED;
      out_valid   <= 1'b0;
      cnt_ra      <= '0;
      cnt_wa      <= '0;
      cnt_rm      <= '0;
      cnt_wm      <= '0;
      cnt_de      <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cfg_we) begin
        case (cfg_index)
          REG_POLICY: policy      <= cfg_data[1:0];
          REG_WAYS:   ways_in_use <= cfg_data;
          REG_QUOTA:  core0_quota <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == ST_SCAN && scan_last && need_rand) lfsr <= lfsr_next;
      if (state == ST_DECIDE && decide_go) begin
        out_valid <= 1'b1;
        cnt_ra    <= cnt_ra_next;
        cnt_wa    <= cnt_wa_next;
        cnt_rm    <= cnt_rm_next;
        cnt_wm    <= cnt_wm_next;
        cnt_de    <= cnt_de_next;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req     <= in_data;
      req_set <= SET_W'(addr_in & ADDR_W'(SETS - 1));
      req_tag <= TAG_W'(addr_in >> SET_SH);
      rc_prod <= {32'd0, addr32_in} * {32'd0, RECIP_LO};
      addr_ph <= 1'b0;
    end
    if (state == ST_ADDR) begin
      addr_ph <= 1'b1;
      if (!addr_ph) begin
        rc_quo <= 32'(rc_sum >> (32 + SET_SH));
      end else begin
        req_set <= rc_set;
        req_tag <= TAG_W'(rc_quo);
      end
    end
    if (state == ST_RAND && div_done) rand_way <= WIDX_W'(div_rem);
    if (state == ST_DECIDE && decide_go) out_data <= rsp;
    if (state == ST_RD) begin
      row       <= ram_rdata;
      scan_w    <= '0;
      hit_found <= 1'b0;
      inv_found <= 1'b0;
      any_found <= 1'b0;
      c0_found  <= 1'b0;
      c1_found  <= 1'b0;
      n0        <= '0;
    end
    if (state == ST_SCAN) begin
      scan_w <= scan_w + 1'b1;
      if (!ent[O_OWNER]) n0 <= n0 + 1'b1;
      if (!hit_found && ent[O_VALID] && (ent[O_OWNER] == req.core_id)
          && (ent[O_TAG +: TAG_W] == req_tag)) begin
        hit_found <= 1'b1;
        hit_way   <= scan_w;
      end
      if (!inv_found && !ent[O_VALID]) begin
        inv_found <= 1'b1;
        inv_way   <= scan_w;
      end
      if (!any_found || (ent[O_STAMP +: STAMP_W] < any_stamp)) begin
        any_found <= 1'b1;
        any_way   <= scan_w;
        any_stamp <= ent[O_STAMP +: STAMP_W];
      end
      if (!ent[O_OWNER] && (!c0_found || (ent[O_STAMP +: STAMP_W] < c0_stamp))) begin
        c0_found <= 1'b1;
        c0_way   <= scan_w;
        c0_stamp <= ent[O_STAMP +: STAMP_W];
      end
      if (ent[O_OWNER] && (!c1_found || (ent[O_STAMP +: STAMP_W] < c1_stamp))) begin
        c1_found <= 1'b1;
        c1_way   <= scan_w;
        c1_stamp <= ent[O_STAMP +: STAMP_W];
      end
    end
  end

  `SACTC_ASSERT_NEXT(a_hold_result, clk, rst, (state == ST_DECIDE) && out_valid && !out_ready, state == ST_DECIDE)
  `SACTC_ASSERT_NOW(a_write_phase, clk, rst, ram_we, (state == ST_CLEAR) || (state == ST_DECIDE))
  `SACTC_ASSERT_NEXT(a_accept_reads, clk, rst, in_valid && in_ready, (state == ST_RD) || (state == ST_ADDR))
  `SACTC_ASSERT_NEXT(a_cnt_mono, clk, rst, 1'b1, cnt_ra >= $past(cnt_ra))

endmodule

FILE: bench/tb_set_assoc_cache_tag_controller.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_controller
// Drives lookup and install beats through the tag store under every
// replacement policy and a range of way counts and quotas. A cycle-free model
// of the tag store predicts each result beat, which is checked field by field.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_tag_controller;
  import sactc_pkg::*;

  localparam int NSETS = 256;
  localparam int NWAYS = 8;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT = 4000;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  req_t in_data;
  rsp_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  set_assoc_cache_tag_controller u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // tag store model
  logic        mv_valid [NSETS*NWAYS];
  logic        mv_dirty [NSETS*NWAYS];
  logic        mv_owner [NSETS*NWAYS];
  logic [23:0] mv_tag   [NSETS*NWAYS];
  logic [31:0] mv_stamp [NSETS*NWAYS];
  logic [15:0] mv_lfsr;
  logic [31:0] mv_cnt [5];
  logic [1:0]  m_policy;
  logic [3:0]  m_ways, m_quota;

  rsp_t pending_rsp[$];
  int   n_err = 0;
  int   idle_stall = 0;
  bit   idle_on = 1;
  int   hold_reqs = 0, hold_seen = 0, hold_cnt = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic void bump(int i);
    if (mv_cnt[i] != CNT_MAX) mv_cnt[i] = mv_cnt[i] + 1;
  endfunction

  function automatic int lru_way(int base, int nw, int sel);
    int best;
    logic [31:0] best_st;
    best = -1;
    best_st = '0;
    for (int w = 0; w < nw; w++) begin
      if (sel != 2 && mv_owner[base+w] != sel[0]) continue;
      if (best < 0 || mv_stamp[base+w] < best_st) begin
        best = w;
        best_st = mv_stamp[base+w];
      end
    end
    return best;
  endfunction

  function automatic rsp_t predict_tag_access(req_t r);
    rsp_t o;
    int base, nw, n0, q0, pick, i;
    logic [23:0] tg;
    bit over0, over1, b;
    o = '0;
    base = int'(r.blk_addr[7:0]) * NWAYS;
    tg = r.blk_addr[31:8];
    nw = m_ways;
    if (nw == 0) nw = 1;
    if (nw > NWAYS) nw = NWAYS;
    pick = -1;
    if (r.mode == MODE_LOOKUP) begin
      for (int w = 0; w < nw; w++) begin
        i = base + w;
        if (mv_valid[i] && mv_owner[i] == r.core_id && mv_tag[i] == tg) begin
          o.hit = 1;
          mv_stamp[i] = r.timestamp;
          if (r.write_op) mv_dirty[i] = 1;
          break;
        end
      end
      bump(r.write_op ? 1 : 0);
      if (!o.hit) bump(r.write_op ? 3 : 2);
    end else begin
      for (int w = 0; w < nw; w++) begin
        if (!mv_valid[base+w]) begin
          pick = w;
          break;
        end
      end
      if (pick < 0) begin
        if (m_policy == POLICY_RAND) begin
          b = mv_lfsr[0] ^ mv_lfsr[2] ^ mv_lfsr[3] ^ mv_lfsr[5];
          mv_lfsr = {b, mv_lfsr[15:1]};
          pick = int'(mv_lfsr) % nw;
        end else if (m_policy == POLICY_PART) begin
          n0 = 0;
          for (int w = 0; w < nw; w++) if (mv_owner[base+w] == 1'b0) n0++;
          q0 = m_quota;
          if (q0 > nw) q0 = nw;
          over0 = n0 > q0;
          over1 = (nw - n0) > (nw - q0);
          if (over0 || (r.core_id == 1'b0 && !over1)) pick = lru_way(base, nw, 0);
          else pick = lru_way(base, nw, 1);
        end else begin
          pick = lru_way(base, nw, 2);
        end
      end
      if (pick < 0) begin
        o.no_victim = 1;
      end else begin
        i = base + pick;
        o.victim_way = pick[2:0];
        if (mv_valid[i]) begin
          o.evict_valid = 1;
          o.evict_dirty = mv_dirty[i];
          o.evict_tag = mv_tag[i];
          o.evict_core = mv_owner[i];
          if (mv_dirty[i]) bump(4);
        end
        mv_valid[i] = 1;
        mv_dirty[i] = r.write_op;
        mv_owner[i] = r.core_id;
        mv_tag[i] = tg;
        mv_stamp[i] = r.timestamp;
      end
    end
    o.read_accesses = mv_cnt[0];
    o.write_accesses = mv_cnt[1];
    o.read_misses = mv_cnt[2];
    o.write_misses = mv_cnt[3];
    o.dirty_evictions = mv_cnt[4];
    return o;
  endfunction

  // one request beat; the model is stepped at acceptance
  task automatic send_req(input req_t r, output rsp_t p);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 12) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    p = predict_tag_access(r);
    pending_rsp.push_back(p);
  endtask

  task automatic send_one(input logic md, input logic [31:0] a, input logic wr,
                          input logic core, input logic [31:0] ts);
    req_t r;
    rsp_t p;
    r.mode = md;
    r.blk_addr = a;
    r.write_op = wr;
    r.core_id = core;
    r.timestamp = ts;
    send_req(r, p);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_POLICY) m_policy = val[1:0];
    else if (idx == REG_WAYS) m_ways = val;
    else if (idx == REG_QUOTA) m_quota = val;
  endtask

  task automatic configure(input logic [3:0] pol, input logic [3:0] ways,
                           input logic [3:0] quota);
    wait_quiet();
    write_reg(REG_POLICY, pol);
    write_reg(REG_WAYS, ways);
    write_reg(REG_QUOTA, quota);
  endtask

  // lookups and some installs, an install after most misses; a few sets and tags so lines collide
  task automatic run_traffic(input int n, input int set_span);
    req_t r;
    rsp_t p;
    int k, sel;
    k = 0;
    while (k < n) begin
      sel = $urandom_range(5);
      r.blk_addr[31:8] = (sel == 5) ? 24'hFFFFFF : 24'(sel);
      r.blk_addr[7:0] = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(set_span - 1));
      if ($urandom_range(9) == 0) r.blk_addr = $urandom;
      r.core_id = $urandom_range(1);
      r.write_op = $urandom_range(1);
      r.timestamp = $urandom;
      r.mode = ($urandom_range(9) == 0) ? MODE_INSTALL : MODE_LOOKUP;
      send_req(r, p);
      k++;
      if (r.mode == MODE_LOOKUP && !p.hit && $urandom_range(9) < 8 && k < n) begin
        r.mode = MODE_INSTALL;
        r.write_op = $urandom_range(1);
        r.timestamp = $urandom;
        send_req(r, p);
        k++;
      end
    end
  endtask

  task automatic test_directed();
    send_one(MODE_LOOKUP, 32'h0, 0, 0, 32'h0);
    send_one(MODE_INSTALL, 32'h0, 1, 0, 32'h0);
    send_one(MODE_LOOKUP, 32'h0, 1, 0, 32'h10);
    send_one(MODE_LOOKUP, 32'h0, 0, 1, 32'h11);
    send_one(MODE_INSTALL, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF);
    send_one(MODE_LOOKUP, 32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF);
    send_one(MODE_LOOKUP, 32'hFFFF_FFFF, 1, 0, 32'h5);
    for (int t = 1; t < 10; t++)
      send_one(MODE_INSTALL, {24'(t), 8'h00}, t[0], t[1], 32'(100 + t));
    send_one(MODE_LOOKUP, {24'd9, 8'h00}, 0, 0, 32'h200);
  endtask

  // partitioning with a quota that leaves core 0 nothing to evict
  task automatic test_no_victim();
    configure(POLICY_PART, 4'd2, 4'd0);
    send_one(MODE_INSTALL, {24'd1, 8'h07}, 1, 1, 32'd1);
    send_one(MODE_INSTALL, {24'd2, 8'h07}, 0, 1, 32'd2);
    send_one(MODE_INSTALL, {24'd3, 8'h07}, 1, 0, 32'd3);
    send_one(MODE_INSTALL, {24'd4, 8'h07}, 0, 1, 32'd4);
    send_one(MODE_LOOKUP, {24'd1, 8'h07}, 0, 1, 32'd5);
  endtask

  task automatic test_lru();
    configure(POLICY_LRU, 4'd8, 4'd4);
    run_traffic(300, 4);
  endtask

  task automatic test_random();
    configure(POLICY_RAND, 4'd8, 4'd4);
    run_traffic(250, 4);
    configure(POLICY_RAND, 4'd5, 4'd15);
    run_traffic(150, 2);
  endtask

  task automatic test_partition();
    configure(POLICY_PART, 4'd8, 4'd4);
    run_traffic(250, 3);
    configure(POLICY_PART, 4'd8, 4'd8);
    run_traffic(150, 3);
    configure(POLICY_PART, 4'd3, 4'd0);
    run_traffic(150, 3);
  endtask

  task automatic test_way_limits();
    configure(4'd3, 4'd1, 4'd15);
    run_traffic(150, 3);
    configure(POLICY_LRU, 4'd0, 4'd0);
    run_traffic(150, 3);
    configure(POLICY_RAND, 4'd15, 4'd2);
    run_traffic(150, 3);
  endtask

  // receiver holds off while the sender keeps offering beats, then both sides run without idle gaps
  task automatic test_backpressure();
    configure(POLICY_LRU, 4'd8, 4'd4);
    hold_reqs++;
    run_traffic(50, 2);
    idle_on = 0;
    run_traffic(200, 8);
    idle_on = 1;
  endtask

  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 12);
    end
  end

  task automatic chk(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      n_err++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result beat with no outstanding request");
        n_err++;
      end else begin
        e = pending_rsp.pop_front();
        chk("hit", e.hit, out_data.hit);
        chk("victim_way", e.victim_way, out_data.victim_way);
        chk("no_victim", e.no_victim, out_data.no_victim);
        chk("evict_valid", e.evict_valid, out_data.evict_valid);
        chk("evict_dirty", e.evict_dirty, out_data.evict_dirty);
        chk("evict_tag", e.evict_tag, out_data.evict_tag);
        chk("evict_core", e.evict_core, out_data.evict_core);
        chk("read_accesses", e.read_accesses, out_data.read_accesses);
        chk("write_accesses", e.write_accesses, out_data.write_accesses);
        chk("read_misses", e.read_misses, out_data.read_misses);
        chk("write_misses", e.write_misses, out_data.write_misses);
        chk("dirty_evictions", e.dirty_evictions, out_data.dirty_evictions);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_stall = 0;
    else idle_stall++;
    if (idle_stall >= STALL_LIMIT) begin
      $display("tb_set_assoc_cache_tag_controller: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      mv_valid[i] = 0;
      mv_dirty[i] = 0;
      mv_owner[i] = 0;
      mv_tag[i] = '0;
      mv_stamp[i] = '0;
    end
    for (int i = 0; i < 5; i++) mv_cnt[i] = '0;
    mv_lfsr = LFSR_SEED;
    m_policy = POLICY_LRU;
    m_ways = 4'd8;
    m_quota = 4'd4;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    test_directed();
    test_no_victim();
    test_lru();
    test_random();
    test_partition();
    test_way_limits();
    test_backpressure();

    wait_quiet();
    if (n_err == 0) $display("tb_set_assoc_cache_tag_controller: clean");
    else $display("tb_set_assoc_cache_tag_controller: errors");
    $finish;
  end

endmodule
